[design/tbn_pkg.sv]
// Package for the triangle tangent/bitangent core.
// Widths, state codes and the status struct shared by all design files.
package tbn_pkg;

    localparam int CW    = 32;          // coordinate width, Q16.16
    localparam int DW    = CW + 1;      // edge / UV delta width
    localparam int PW    = 2 * DW;      // product width
    localparam int TW    = PW + 1;      // difference of two products
    localparam int MW    = TW - 1;      // magnitude width
    localparam int NB    = 30;          // normalised magnitude bits
    localparam int SW    = 2 * NB + 2;  // sum of three squares
    localparam int LW    = NB + 1;      // root width
    localparam int OW    = 16;          // Q1.14 output width
    localparam int FRAC  = 14;
    localparam int QW    = 16;          // quotient bits
    localparam int NTERM = 7;           // det, three tangent, three bitangent terms
    localparam int NSTEP = 14;          // products per triangle
    localparam int SHW   = 8;           // coarse shift step while normalising

    localparam logic [QW-1:0] OUT_ONE = QW'(16384);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_FLIP = 5'b00100,
        S_NT   = 5'b01000,
        S_NB   = 5'b10000
    } t_top_state;

    typedef enum logic [6:0] {
        N_IDLE  = 7'b0000001,
        N_SHIFT = 7'b0000010,
        N_SQR   = 7'b0000100,
        N_ROOT  = 7'b0001000,
        N_DLOAD = 7'b0010000,
        N_DIV   = 7'b0100000,
        N_DONE  = 7'b1000000
    } t_norm_state;

    typedef struct packed {
        logic done;
        logic zero;
    } t_norm_stat;

endpackage

[design/tbn_if.sv]
// Valid/ready channel interfaces for vertex words and result words.
// Depends on tbn_pkg for field widths.
interface tbn_vtx_if;
    logic                             valid;
    logic                             ready;
    logic signed [tbn_pkg::CW-1:0]    pos_x;
    logic signed [tbn_pkg::CW-1:0]    pos_y;
    logic signed [tbn_pkg::CW-1:0]    pos_z;
    logic signed [tbn_pkg::CW-1:0]    tex_u;
    logic signed [tbn_pkg::CW-1:0]    tex_v;
    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface tbn_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [tbn_pkg::OW-1:0]    tan_x;
    logic signed [tbn_pkg::OW-1:0]    tan_y;
    logic signed [tbn_pkg::OW-1:0]    tan_z;
    logic signed [tbn_pkg::OW-1:0]    bitan_x;
    logic signed [tbn_pkg::OW-1:0]    bitan_y;
    logic signed [tbn_pkg::OW-1:0]    bitan_z;
    logic                             degenerate;
    modport source (output valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                    degenerate, input ready);
    modport sink   (input valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                    degenerate, output ready);
endinterface

[design/triangle_tangent_bitangent_core.sv]
// Triangle tangent/bitangent core: vertex capture, shared multiplier
// sequencer and result register. Depends on tbn_pkg, tbn_if, tbn_norm.
//
// Use: vertex words arrive on i_vtx (valid/ready), three per triangle.
// The first two are held and give no result; the third starts the work
// and one result word leaves on o_res (valid/ready) per triangle.
// The products of a triangle go through one 33x33 multiplier, then a
// sign-fix step, then two passes of the normaliser (each a shift
// search, squares, a bit-serial root, three divides and a handover).
// Ready is low while a triangle is at work.
// A zero UV determinant skips normalisation and gives a degenerate result.
// Vertices 1 and 2 are taken at one per cycle while idle.
// Reset clears the vertex phase and drops any pending result.
// When the receiver stalls, the result word holds; the first two vertices
// of the next triangle are still taken, the third waits until it is gone.
module triangle_tangent_bitangent_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tbn_vtx_if.sink    i_vtx,
    tbn_res_if.source  o_res
);

    tbn_pkg::t_top_state r_state;
    logic [1:0]                    r_phase;
    logic signed [tbn_pkg::CW-1:0] r_hold [0:1][0:4];
    logic signed [tbn_pkg::DW-1:0] r_e1 [0:2];
    logic signed [tbn_pkg::DW-1:0] r_e2 [0:2];
    logic signed [tbn_pkg::DW-1:0] r_du1, r_dv1, r_du2, r_dv2;
    logic [3:0]                    r_step;
    logic signed [tbn_pkg::PW-1:0] r_prod;
    logic signed [tbn_pkg::TW-1:0] r_term [0:tbn_pkg::NTERM-1];
    logic                          r_launch;
    logic                          r_tzero;
    logic signed [tbn_pkg::OW-1:0] r_tan [0:2];
    logic                          r_out_valid;
    logic signed [tbn_pkg::OW-1:0] r_out [0:5];
    logic                          r_out_degen;

    logic                          w_accept;
    logic signed [tbn_pkg::CW-1:0] w_in [0:4];
    logic signed [tbn_pkg::DW-1:0] w_a, w_b;
    logic signed [tbn_pkg::PW-1:0] w_prod;
    logic [3:0]                    w_pidx;
    logic signed [tbn_pkg::TW-1:0] w_comp [0:2];
    tbn_pkg::t_norm_stat           w_nstat;
    logic signed [tbn_pkg::OW-1:0] w_unit [0:2];

    assign w_in[0] = i_vtx.pos_x;
    assign w_in[1] = i_vtx.pos_y;
    assign w_in[2] = i_vtx.pos_z;
    assign w_in[3] = i_vtx.tex_u;
    assign w_in[4] = i_vtx.tex_v;

    assign i_vtx.ready = (r_state == tbn_pkg::S_IDLE) &&
                         !((r_phase == 2'd2) && r_out_valid);
    assign w_accept    = i_vtx.valid && i_vtx.ready;

    // operand select for the shared multiplier
    always_comb begin
        case (r_step)
            4'd0:    begin w_a = r_du1; w_b = r_dv2;   end
            4'd1:    begin w_a = r_du2; w_b = r_dv1;   end
            4'd2:    begin w_a = r_dv2; w_b = r_e1[0]; end
            4'd3:    begin w_a = r_dv1; w_b = r_e2[0]; end
            4'd4:    begin w_a = r_dv2; w_b = r_e1[1]; end
            4'd5:    begin w_a = r_dv1; w_b = r_e2[1]; end
            4'd6:    begin w_a = r_dv2; w_b = r_e1[2]; end
            4'd7:    begin w_a = r_dv1; w_b = r_e2[2]; end
            4'd8:    begin w_a = r_du1; w_b = r_e2[0]; end
            4'd9:    begin w_a = r_du2; w_b = r_e1[0]; end
            4'd10:   begin w_a = r_du1; w_b = r_e2[1]; end
            4'd11:   begin w_a = r_du2; w_b = r_e1[1]; end
            4'd12:   begin w_a = r_du1; w_b = r_e2[2]; end
            4'd13:   begin w_a = r_du2; w_b = r_e1[2]; end
            default: begin w_a = '0;    w_b = '0;      end
        endcase
    end

    assign w_prod = w_a * w_b;
    assign w_pidx = r_step - 4'd1;

    always_comb begin
        if (r_state == tbn_pkg::S_NB) begin
            w_comp[0] = r_term[4];
            w_comp[1] = r_term[5];
            w_comp[2] = r_term[6];
        end else begin
            w_comp[0] = r_term[1];
            w_comp[1] = r_term[2];
            w_comp[2] = r_term[3];
        end
    end

    tbn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_launch),
        .i_comp  (w_comp),
        .o_stat  (w_nstat),
        .o_unit  (w_unit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tbn_pkg::S_IDLE;
            r_phase     <= '0;
            r_step      <= '0;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            if (o_res.valid && o_res.ready)
                r_out_valid <= 1'b0;
            case (r_state)
                tbn_pkg::S_IDLE: begin
                    if (w_accept) begin
                        if (r_phase == 2'd2) begin
                            for (int i = 0; i < 3; i++) begin
                                r_e1[i] <= tbn_pkg::DW'(r_hold[1][i])
                                         - tbn_pkg::DW'(r_hold[0][i]);
                                r_e2[i] <= tbn_pkg::DW'(w_in[i])
                                         - tbn_pkg::DW'(r_hold[0][i]);
                            end
                            r_du1   <= tbn_pkg::DW'(r_hold[1][3]) - tbn_pkg::DW'(r_hold[0][3]);
                            r_dv1   <= tbn_pkg::DW'(r_hold[1][4]) - tbn_pkg::DW'(r_hold[0][4]);
                            r_du2   <= tbn_pkg::DW'(w_in[3]) - tbn_pkg::DW'(r_hold[0][3]);
                            r_dv2   <= tbn_pkg::DW'(w_in[4]) - tbn_pkg::DW'(r_hold[0][4]);
                            r_phase <= '0;
                            r_step  <= '0;
                            r_state <= tbn_pkg::S_MUL;
                        end else begin
                            for (int i = 0; i < 5; i++)
                                r_hold[r_phase[0]][i] <= w_in[i];
                            r_phase <= r_phase + 2'd1;
                        end
                    end
                end
                tbn_pkg::S_MUL: begin
                    // product of this step registered; previous one folded in
                    r_prod <= w_prod;
                    if (r_step != 4'd0) begin
                        if (!w_pidx[0])
                            r_term[w_pidx[3:1]] <= tbn_pkg::TW'(r_prod);
                        else
                            r_term[w_pidx[3:1]] <= r_term[w_pidx[3:1]]
                                                 - tbn_pkg::TW'(r_prod);
                    end
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'(tbn_pkg::NSTEP))
                        r_state <= tbn_pkg::S_FLIP;
                end
                tbn_pkg::S_FLIP: begin
                    if (r_term[0] == '0) begin
                        for (int i = 0; i < 6; i++)
                            r_out[i] <= '0;
                        r_out_degen <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_state     <= tbn_pkg::S_IDLE;
                    end else begin
                        if (r_term[0][tbn_pkg::TW-1]) begin
                            for (int i = 1; i < tbn_pkg::NTERM; i++)
                                r_term[i] <= -r_term[i];
                        end
                        r_launch <= 1'b1;
                        r_state  <= tbn_pkg::S_NT;
                    end
                end
                tbn_pkg::S_NT: begin
                    if (w_nstat.done) begin
                        r_tan    <= w_unit;
                        r_tzero  <= w_nstat.zero;
                        r_launch <= 1'b1;
                        r_state  <= tbn_pkg::S_NB;
                    end
                end
                tbn_pkg::S_NB: begin
                    if (w_nstat.done) begin
                        if (r_tzero || w_nstat.zero) begin
                            for (int i = 0; i < 6; i++)
                                r_out[i] <= '0;
                            r_out_degen <= 1'b1;
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                r_out[i]     <= r_tan[i];
                                r_out[3 + i] <= w_unit[i];
                            end
                            r_out_degen <= 1'b0;
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= tbn_pkg::S_IDLE;
                    end
                end
                default: r_state <= tbn_pkg::S_IDLE;
            endcase
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.tan_x      = r_out[0];
    assign o_res.tan_y      = r_out[1];
    assign o_res.tan_z      = r_out[2];
    assign o_res.bitan_x    = r_out[3];
    assign o_res.bitan_y    = r_out[4];
    assign o_res.bitan_z    = r_out[5];
    assign o_res.degenerate = r_out_degen;

endmodule

[design/tbn_norm.sv]
// Iterative vector normaliser: shift search, sum of squares, bit-serial
// square root and restoring divide. Depends on tbn_pkg.
module tbn_norm (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [tbn_pkg::TW-1:0]   i_comp [0:2],
    output tbn_pkg::t_norm_stat             o_stat,
    output logic signed [tbn_pkg::OW-1:0]   o_unit [0:2]
);

    tbn_pkg::t_norm_state r_state;
    logic [tbn_pkg::MW-1:0]        r_mag [0:2];
    logic                          r_neg [0:2];
    logic [4:0]                    r_cnt;
    logic [1:0]                    r_idx;
    logic [2*tbn_pkg::NB-1:0]      r_sq;
    logic [tbn_pkg::SW-1:0]        r_sum;
    logic [tbn_pkg::SW-1:0]        r_x;
    logic [tbn_pkg::SW-1:0]        r_root;
    logic [tbn_pkg::SW-1:0]        r_bit;
    logic [tbn_pkg::LW-1:0]        r_rem;
    logic [tbn_pkg::QW-1:0]        r_numlo;
    logic [tbn_pkg::QW-1:0]        r_q;
    logic signed [tbn_pkg::OW-1:0] r_unit [0:2];
    logic                          r_done;
    logic                          r_zero;

    logic [tbn_pkg::MW-1:0]        w_or;
    logic [tbn_pkg::NB-1:0]        w_v;
    logic [tbn_pkg::SW-1:0]        w_trial;
    logic [tbn_pkg::LW-1:0]        w_len;
    logic [tbn_pkg::NB+tbn_pkg::FRAC:0] w_num;
    logic [tbn_pkg::LW:0]          w_rem2;
    logic                          w_qbit;
    logic [tbn_pkg::QW-1:0]        w_qn;
    logic [tbn_pkg::QW-1:0]        w_qc;

    assign w_or = r_mag[0] | r_mag[1] | r_mag[2];

    // component select: square pass by counter, divide pass by index
    always_comb begin
        logic [1:0] sel;
        sel = (r_state == tbn_pkg::N_SQR) ? r_cnt[1:0] : r_idx;
        case (sel)
            2'd0:    w_v = r_mag[0][tbn_pkg::MW-1 -: tbn_pkg::NB];
            2'd1:    w_v = r_mag[1][tbn_pkg::MW-1 -: tbn_pkg::NB];
            2'd2:    w_v = r_mag[2][tbn_pkg::MW-1 -: tbn_pkg::NB];
            default: w_v = '0;
        endcase
    end

    assign w_trial = r_root + r_bit;
    assign w_len   = r_root[tbn_pkg::LW-1:0];
    assign w_num   = {1'b0, w_v, {tbn_pkg::FRAC{1'b0}}}
                   + (tbn_pkg::NB+tbn_pkg::FRAC+1)'(w_len >> 1);
    assign w_rem2  = {r_rem, r_numlo[tbn_pkg::QW-1]};
    assign w_qbit  = (w_rem2 >= {1'b0, w_len});
    assign w_qn    = {r_q[tbn_pkg::QW-2:0], w_qbit};
    assign w_qc    = (w_qn > tbn_pkg::OUT_ONE) ? tbn_pkg::OUT_ONE : w_qn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbn_pkg::N_IDLE;
            r_done  <= 1'b0;
            r_zero  <= 1'b0;
            r_cnt   <= '0;
            r_idx   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                tbn_pkg::N_IDLE: begin
                    if (i_start) begin
                        for (int i = 0; i < 3; i++) begin
                            r_neg[i] <= i_comp[i][tbn_pkg::TW-1];
                            r_mag[i] <= tbn_pkg::MW'(i_comp[i][tbn_pkg::TW-1] ?
                                        -i_comp[i] : i_comp[i]);
                        end
                        r_state <= tbn_pkg::N_SHIFT;
                    end
                end
                tbn_pkg::N_SHIFT: begin
                    if (w_or == '0) begin
                        r_zero  <= 1'b1;
                        r_state <= tbn_pkg::N_DONE;
                    end else if (w_or[tbn_pkg::MW-1 -: tbn_pkg::SHW] == '0) begin
                        for (int i = 0; i < 3; i++)
                            r_mag[i] <= r_mag[i] << tbn_pkg::SHW;
                    end else if (!w_or[tbn_pkg::MW-1]) begin
                        for (int i = 0; i < 3; i++)
                            r_mag[i] <= r_mag[i] << 1;
                    end else begin
                        r_zero  <= 1'b0;
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_state <= tbn_pkg::N_SQR;
                    end
                end
                tbn_pkg::N_SQR: begin
                    // one squarer; product registered, summed next cycle
                    r_sq <= w_v * w_v;
                    if (r_cnt != 5'd0)
                        r_sum <= r_sum + tbn_pkg::SW'(r_sq);
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd3) begin
                        r_x     <= r_sum + tbn_pkg::SW'(r_sq);
                        r_root  <= '0;
                        r_bit   <= tbn_pkg::SW'(1) << (tbn_pkg::SW - 2);
                        r_cnt   <= '0;
                        r_state <= tbn_pkg::N_ROOT;
                    end
                end
                tbn_pkg::N_ROOT: begin
                    if (r_x >= w_trial) begin
                        r_x    <= r_x - w_trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(tbn_pkg::SW / 2 - 1)) begin
                        r_idx   <= '0;
                        r_state <= tbn_pkg::N_DLOAD;
                    end
                end
                tbn_pkg::N_DLOAD: begin
                    r_rem   <= tbn_pkg::LW'(w_num >> tbn_pkg::QW);
                    r_numlo <= w_num[tbn_pkg::QW-1:0];
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= tbn_pkg::N_DIV;
                end
                tbn_pkg::N_DIV: begin
                    r_rem   <= w_qbit ? tbn_pkg::LW'(w_rem2 - {1'b0, w_len})
                                      : tbn_pkg::LW'(w_rem2);
                    r_numlo <= r_numlo << 1;
                    r_q     <= w_qn;
                    r_cnt   <= r_cnt + 5'd1;
                    if (r_cnt == 5'(tbn_pkg::QW - 1)) begin
                        case (r_idx)
                            2'd0:    r_unit[0] <= r_neg[0] ? -w_qc : w_qc;
                            2'd1:    r_unit[1] <= r_neg[1] ? -w_qc : w_qc;
                            default: r_unit[2] <= r_neg[2] ? -w_qc : w_qc;
                        endcase
                        if (r_idx == 2'd2) begin
                            r_state <= tbn_pkg::N_DONE;
                        end else begin
                            r_idx   <= r_idx + 2'd1;
                            r_state <= tbn_pkg::N_DLOAD;
                        end
                    end
                end
                tbn_pkg::N_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= tbn_pkg::N_IDLE;
                end
                default: r_state <= tbn_pkg::N_IDLE;
            endcase
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.zero = r_zero;
    assign o_unit      = r_unit;

endmodule
